// ===== hw/rtl/pwoc_pkg.sv =====
// Shared types and constants for the periodic window overlap check.
package pwoc_pkg;

	localparam int T0_W    = 48;       // start time: coarse seconds and 16-bit fine
	localparam int TC_W    = T0_W + 1; // centre and end carry one more bit
	localparam int DUR_W   = 24;
	localparam int REG_W   = 32;
	localparam int W64     = 64;
	localparam int WC_W    = TC_W + 1; // window start before the period step
	localparam int NCELL   = TC_W;     // one divider cell per dividend bit
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [2:0] REG_FILTER_ENABLE   = 3'd0;
	localparam logic [2:0] REG_PERIOD_FINE     = 3'd1;
	localparam logic [2:0] REG_OFFSET_FINE     = 3'd2;
	localparam logic [2:0] REG_SHIFT_FINE      = 3'd3;
	localparam logic [2:0] REG_BAD_LENGTH_FINE = 3'd4;
	localparam logic [2:0] REG_DURATION_CH0    = 3'd5;
	localparam logic [2:0] REG_DURATION_CH1    = 3'd6;
	localparam logic [2:0] REG_DURATION_CH2    = 3'd7;

	localparam logic [1:0] CH0 = 2'd0;
	localparam logic [1:0] CH1 = 2'd1;
	localparam logic [1:0] CH2 = 2'd2;

	localparam logic [1:0] WIN_PREV = 2'd0;
	localparam logic [1:0] WIN_CUR  = 2'd1;
	localparam logic [1:0] WIN_NEXT = 2'd2;

	typedef struct packed {
		logic             filter_enable;
		logic [REG_W-1:0] period_fine;
		logic [REG_W-1:0] offset_fine;
		logic [REG_W-1:0] shift_fine;
		logic [REG_W-1:0] bad_length_fine;
		logic [DUR_W-1:0] duration_ch0;
		logic [DUR_W-1:0] duration_ch1;
		logic [DUR_W-1:0] duration_ch2;
	} pwoc_cfg_t;

	// word travelling down the divider chain
	typedef struct packed {
		logic [TC_W-1:0]  tc;
		logic [T0_W-1:0]  t0;
		logic [TC_W-1:0]  t1;
		logic [REG_W-1:0] rem;
	} pwoc_item_t;

endpackage

// ===== hw/rtl/periodic_window_overlap_check.sv =====
// Periodic interference window overlap check: top level.
//
// Input: a word (coarse_time, fine_time, channel) is taken on a rising edge with start
// high and busy low. busy stays low, so a word may be offered on every cycle.
// Output: done is high for exactly one cycle with polluted valid alongside it; the
// receiver cannot stall and must take the word in that cycle.
// Throughput: one word per cycle.
// The divider chain has 49 cells, one per bit of the acquisition centre,
// each a 33-bit compare and subtract against the period, followed by a subtract for
// the period base, an add for the window offset, the per-window period step, the
// window end add and the overlap compare.
// Words in flight never interact; there is no state between words.
// Reset clears the configuration registers and all valid flags; words in flight are
// dropped. The user must write configuration through the APB port only while no word
// is in flight (unenforced); registers at byte address 4*i read back stored bits.
// With filtering off, zero window length or zero period, polluted reads 0.
module periodic_window_overlap_check (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [31:0]                  coarse_time,
	input  logic [15:0]                  fine_time,
	input  logic [1:0]                   channel,
	output logic                         done,
	output logic                         polluted,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pwoc_pkg::PADDR_W-1:0] paddr,
	input  logic [pwoc_pkg::PDATA_W-1:0] pwdata,
	output logic [pwoc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import pwoc_pkg::*;

	pwoc_cfg_t        cfg;
	logic             accept;
	logic [T0_W-1:0]  t0_in;
	logic [DUR_W-1:0] dur_in;
	pwoc_item_t       item_in;
	logic             v_s1;
	pwoc_item_t       item_s1;
	logic             chain_valid [NCELL+1];
	pwoc_item_t       chain_item  [NCELL+1];
	logic             v_s2;
	logic [TC_W-1:0]  base_s2;
	logic [T0_W-1:0]  t0_s2;
	logic [TC_W-1:0]  t1_s2;
	logic             v_s3;
	logic [WC_W-1:0]  w0c_s3;
	logic [T0_W-1:0]  t0_s3;
	logic [TC_W-1:0]  t1_s3;
	logic             v_s4;
	logic [T0_W-1:0]  t0_s4;
	logic [TC_W-1:0]  t1_s4;
	logic             v_s5;
	logic [T0_W-1:0]  t0_s5;
	logic [TC_W-1:0]  t1_s5;
	logic [REG_W:0]   off_shift;
	logic [2:0]       hits;
	logic             check_en;
	logic             done_q;
	logic             polluted_q;

	pwoc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// input stage: start, end and centre of the acquisition
	always_comb begin
		t0_in = {coarse_time, fine_time};
		case (channel)
			CH0:     dur_in = cfg.duration_ch0;
			CH1:     dur_in = cfg.duration_ch1;
			CH2:     dur_in = cfg.duration_ch2;
			default: dur_in = '0;
		endcase
		item_in.t0  = t0_in;
		item_in.t1  = {1'b0, t0_in} + {{(TC_W-DUR_W){1'b0}}, dur_in};
		item_in.tc  = {1'b0, t0_in} + {{(TC_W-DUR_W+1){1'b0}}, dur_in[DUR_W-1:1]};
		item_in.rem = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_in;
	end

	assign chain_valid[0] = v_s1;
	assign chain_item[0]  = item_s1;

	// remainder of the centre modulo the period, most significant bit first
	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		pwoc_div_cell #(
			.BIT_IDX (TC_W - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_item   (chain_item[k]),
			.divisor   (cfg.period_fine),
			.out_valid (chain_valid[k+1]),
			.out_item  (chain_item[k+1])
		);
	end

	assign off_shift = {1'b0, cfg.offset_fine} + {1'b0, cfg.shift_fine};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s2 <= chain_valid[NCELL];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		base_s2 <= chain_item[NCELL].tc
			- {{(TC_W-REG_W){1'b0}}, chain_item[NCELL].rem};
		t0_s2   <= chain_item[NCELL].t0;
		t1_s2   <= chain_item[NCELL].t1;
		w0c_s3  <= {1'b0, base_s2} + {{(WC_W-REG_W-1){1'b0}}, off_shift};
		t0_s3   <= t0_s2;
		t1_s3   <= t1_s2;
		t0_s4   <= t0_s3;
		t1_s4   <= t1_s3;
		t0_s5   <= t0_s4;
		t1_s5   <= t1_s4;
	end

	pwoc_window u_win_prev (
		.clk        (clk),
		.win_sel    (WIN_PREV),
		.w0c        (w0c_s3),
		.period     (cfg.period_fine),
		.bad_length (cfg.bad_length_fine),
		.t0         (t0_s5),
		.t1         (t1_s5),
		.hit        (hits[0])
	);

	pwoc_window u_win_cur (
		.clk        (clk),
		.win_sel    (WIN_CUR),
		.w0c        (w0c_s3),
		.period     (cfg.period_fine),
		.bad_length (cfg.bad_length_fine),
		.t0         (t0_s5),
		.t1         (t1_s5),
		.hit        (hits[1])
	);

	pwoc_window u_win_next (
		.clk        (clk),
		.win_sel    (WIN_NEXT),
		.w0c        (w0c_s3),
		.period     (cfg.period_fine),
		.bad_length (cfg.bad_length_fine),
		.t0         (t0_s5),
		.t1         (t1_s5),
		.hit        (hits[2])
	);

	assign check_en = cfg.filter_enable & (|cfg.bad_length_fine) & (|cfg.period_fine);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			polluted_q <= 1'b0;
		end else begin
			done_q     <= v_s5;
			polluted_q <= v_s5 & check_en & (|hits);
		end
	end

	assign done     = done_q;
	assign polluted = polluted_q;

	// a word leaves the divider chain and passes v_s2, v_s3, v_s4, v_s5 and done_q to done
	a_done_follows_chain: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(chain_valid[NCELL], 5))
		else $error("done without a word leaving the divider chain");

	// the remainder never exceeds the dividend prefix it came from
	a_rem_below_centre: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[NCELL] |-> ({{(TC_W-REG_W){1'b0}}, chain_item[NCELL].rem}
			<= chain_item[NCELL].tc))
		else $error("divider remainder above the centre time");

	a_polluted_only_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		polluted |-> done)
		else $error("polluted raised outside a result cycle");

endmodule

// ===== hw/rtl/pwoc_cfg.sv =====
// Configuration registers behind the APB-style port.
module pwoc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pwoc_pkg::PADDR_W-1:0]  paddr,
	input  logic [pwoc_pkg::PDATA_W-1:0]  pwdata,
	output logic [pwoc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output pwoc_pkg::pwoc_cfg_t           cfg
);
	import pwoc_pkg::*;

	pwoc_cfg_t  cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FILTER_ENABLE:   cfg_q.filter_enable   <= pwdata[0];
				REG_PERIOD_FINE:     cfg_q.period_fine     <= pwdata[REG_W-1:0];
				REG_OFFSET_FINE:     cfg_q.offset_fine     <= pwdata[REG_W-1:0];
				REG_SHIFT_FINE:      cfg_q.shift_fine      <= pwdata[REG_W-1:0];
				REG_BAD_LENGTH_FINE: cfg_q.bad_length_fine <= pwdata[REG_W-1:0];
				REG_DURATION_CH0:    cfg_q.duration_ch0    <= pwdata[DUR_W-1:0];
				REG_DURATION_CH1:    cfg_q.duration_ch1    <= pwdata[DUR_W-1:0];
				default:             cfg_q.duration_ch2    <= pwdata[DUR_W-1:0];
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FILTER_ENABLE:   prdata = {{(PDATA_W-1){1'b0}}, cfg_q.filter_enable};
			REG_PERIOD_FINE:     prdata = cfg_q.period_fine;
			REG_OFFSET_FINE:     prdata = cfg_q.offset_fine;
			REG_SHIFT_FINE:      prdata = cfg_q.shift_fine;
			REG_BAD_LENGTH_FINE: prdata = cfg_q.bad_length_fine;
			REG_DURATION_CH0:    prdata = {{(PDATA_W-DUR_W){1'b0}}, cfg_q.duration_ch0};
			REG_DURATION_CH1:    prdata = {{(PDATA_W-DUR_W){1'b0}}, cfg_q.duration_ch1};
			default:             prdata = {{(PDATA_W-DUR_W){1'b0}}, cfg_q.duration_ch2};
		endcase
	end

endmodule

// ===== hw/rtl/pwoc_div_cell.sv =====
// One restoring-division cell: brings in one dividend bit and conditionally subtracts.
module pwoc_div_cell #(
	parameter int BIT_IDX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  pwoc_pkg::pwoc_item_t         in_item,
	input  logic [pwoc_pkg::REG_W-1:0]   divisor,
	output logic                         out_valid,
	output pwoc_pkg::pwoc_item_t         out_item
);
	import pwoc_pkg::*;

	logic [REG_W:0] rem_ext;
	logic [REG_W:0] diff;
	logic           ge;
	pwoc_item_t     nxt_item;
	logic           valid_q;
	pwoc_item_t     item_q;

	always_comb begin
		rem_ext      = {in_item.rem, in_item.tc[BIT_IDX]};
		diff         = rem_ext - {1'b0, divisor};
		ge           = rem_ext >= {1'b0, divisor};
		nxt_item     = in_item;
		// after a subtract the remainder is below the divisor, so 32 bits suffice
		nxt_item.rem = ge ? diff[REG_W-1:0] : rem_ext[REG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= nxt_item;
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

// ===== hw/rtl/pwoc_window.sv =====
// One interference window: places it one period before, at or after the base and tests overlap.
module pwoc_window (
	input  logic                         clk,
	input  logic [1:0]                   win_sel,
	input  logic [pwoc_pkg::WC_W-1:0]    w0c,
	input  logic [pwoc_pkg::REG_W-1:0]   period,
	input  logic [pwoc_pkg::REG_W-1:0]   bad_length,
	input  logic [pwoc_pkg::T0_W-1:0]    t0,
	input  logic [pwoc_pkg::TC_W-1:0]    t1,
	output logic                         hit
);
	import pwoc_pkg::*;

	logic [W64-1:0] base64;
	logic [W64-1:0] step64;
	logic [W64-1:0] w0_nxt;
	logic [W64-1:0] w0_s1;
	logic [W64-1:0] w0_s2;
	logic [W64-1:0] w1_s2;
	logic [W64-1:0] a0;
	logic [W64-1:0] a1;

	always_comb begin
		base64 = {{(W64-WC_W){1'b0}}, w0c};
		step64 = {{(W64-REG_W){1'b0}}, period};
		case (win_sel)
			WIN_PREV: w0_nxt = base64 - step64; // wraps below zero as 64-bit
			WIN_NEXT: w0_nxt = base64 + step64;
			default:  w0_nxt = base64;
		endcase
	end

	always_ff @(posedge clk) begin
		w0_s1 <= w0_nxt;
		w0_s2 <= w0_s1;
		w1_s2 <= w0_s1 + {{(W64-REG_W){1'b0}}, bad_length};
	end

	assign a0 = {{(W64-T0_W){1'b0}}, t0};
	assign a1 = {{(W64-TC_W){1'b0}}, t1};

	assign hit = ((w0_s2 < a0) && (a0 < w1_s2))
		|| ((w0_s2 < a1) && (a1 < w1_s2))
		|| ((a0 < w0_s2) && (w1_s2 < a1))
		|| ((w0_s2 < a0) && (a1 < w1_s2));

endmodule
